[rtl/shift_and_substring_search_unit_macros.svh]
// assertion macros used by ssu_match_core
// no dependencies; pulled in by `include where assertions are written
`ifndef SHIFT_AND_SUBSTRING_SEARCH_UNIT_MACROS_SVH
`define SHIFT_AND_SUBSTRING_SEARCH_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define SSU_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define SSU_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/ssu_pkg.sv]
// shared constants, register codes and config struct of the substring search unit
// no dependencies
package ssu_pkg;

    localparam int MAX_PATTERN_DEF    = 16;
    localparam int POSITION_WIDTH_DEF = 16;

    localparam int BYTE_W      = 8;
    localparam int PAT_BYTES   = 16;
    localparam int PAT_W       = PAT_BYTES * BYTE_W;
    localparam int REG_W       = 32;
    localparam int LEN_W       = 5;
    localparam int PADDR_W     = 5;
    localparam int REG_IDX_W   = 3;
    localparam int HIT_START_W = 16;

    localparam logic [REG_IDX_W-1:0] REG_PAT_0_3   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_PAT_4_7   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_PAT_8_11  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_PAT_12_15 = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_PAT_LEN   = 3'd4;

    localparam logic [LEN_W-1:0] LEN_RESET = 5'd1;

    typedef struct packed {
        logic [PAT_W-1:0] pattern;
        logic [LEN_W-1:0] length;
    } cfg_t;

endpackage

[rtl/shift_and_substring_search_unit.sv]
// top level of the streaming shift-and substring search unit
// depends on ssu_pkg, ssu_apb_regs and ssu_match_core
//
// usage:
//   configure the pattern through the apb port: four 32-bit words of pattern
//   bytes (byte 0 in the low bits of the first word) and the pattern length
//   at byte address 0x10. a length of zero acts as one, a length above
//   MAX_PATTERN acts as MAX_PATTERN. write configuration only while idle.
//   text bytes arrive on the s_ channel; s_text_start marks the first byte
//   of a new text and clears the match vector, position and first-hit flag.
//   every input transaction yields exactly one result transaction on the m_
//   channel: hit, start position of the occurrence, first-hit flag and the
//   position saturation flag.
//   with m_ready high a byte passes the compare stage register and the
//   result register in that order; one byte is taken per cycle while the
//   receiver does not stall. the search state sits in a one-entry ram read
//   at acceptance and written back when the byte advances; a write at the
//   same edge as the read is bypassed, so back-to-back bytes see fresh state.
//   reset clears the match state, the registers (length 1) and all valid
//   flags. when the receiver stalls, the result register holds and one more
//   byte is buffered in the compare stage before s_ready drops.
module shift_and_substring_search_unit
    import ssu_pkg::*;
#(
    parameter int MAX_PATTERN    = MAX_PATTERN_DEF,
    parameter int POSITION_WIDTH = POSITION_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_W-1:0]     paddr,
    input  logic [REG_W-1:0]       pwdata,
    output logic [REG_W-1:0]       prdata,
    output logic                   pready,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [BYTE_W-1:0]      s_text_byte,
    input  logic                   s_text_start,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_hit,
    output logic [HIT_START_W-1:0] m_hit_start,
    output logic                   m_first_hit,
    output logic                   m_position_saturated
);

    cfg_t cfg;

    ssu_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ssu_match_core #(
        .MAX_PATTERN    (MAX_PATTERN),
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_core (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg                  (cfg),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_text_byte          (s_text_byte),
        .s_text_start         (s_text_start),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_hit                (m_hit),
        .m_hit_start          (m_hit_start),
        .m_first_hit          (m_first_hit),
        .m_position_saturated (m_position_saturated)
    );

endmodule

[rtl/ssu_ram.sv]
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module ssu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/ssu_apb_regs.sv]
// apb configuration registers: pattern words and pattern length
// depends on ssu_pkg
module ssu_apb_regs
    import ssu_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [REG_W-1:0]   pwdata,
    output logic [REG_W-1:0]   prdata,
    output logic               pready,
    output cfg_t               cfg
);

    logic [REG_W-1:0]     pat_reg [4];
    logic [LEN_W-1:0]     len_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_stb;

    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr_stb  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_reg[0] <= '0;
            pat_reg[1] <= '0;
            pat_reg[2] <= '0;
            pat_reg[3] <= '0;
            len_reg    <= LEN_RESET;
        end else if (wr_stb) begin
            unique case (reg_idx)
                REG_PAT_0_3:   pat_reg[0] <= pwdata;
                REG_PAT_4_7:   pat_reg[1] <= pwdata;
                REG_PAT_8_11:  pat_reg[2] <= pwdata;
                REG_PAT_12_15: pat_reg[3] <= pwdata;
                REG_PAT_LEN:   len_reg    <= pwdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_PAT_0_3:   prdata = pat_reg[0];
            REG_PAT_4_7:   prdata = pat_reg[1];
            REG_PAT_8_11:  prdata = pat_reg[2];
            REG_PAT_12_15: prdata = pat_reg[3];
            REG_PAT_LEN:   prdata = REG_W'(len_reg);
            default:       prdata = '0;
        endcase
    end

    assign cfg.pattern = {pat_reg[3], pat_reg[2], pat_reg[1], pat_reg[0]};
    assign cfg.length  = len_reg;

endmodule

[rtl/ssu_match_core.sv]
// match pipeline: byte compare stage with state read-modify-write, then result register
// depends on ssu_pkg, ssu_ram and the assertion macro header
`include "shift_and_substring_search_unit_macros.svh"

module ssu_match_core
    import ssu_pkg::*;
#(
    parameter int MAX_PATTERN    = MAX_PATTERN_DEF,
    parameter int POSITION_WIDTH = POSITION_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  cfg_t                   cfg,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [BYTE_W-1:0]      s_text_byte,
    input  logic                   s_text_start,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_hit,
    output logic [HIT_START_W-1:0] m_hit_start,
    output logic                   m_first_hit,
    output logic                   m_position_saturated
);

    // state word: {found, position, match vector}
    localparam int ST_W   = MAX_PATTERN + POSITION_WIDTH + 1;
    localparam int VEC_LO = 0;
    localparam int POS_LO = MAX_PATTERN;
    localparam int FND_B  = MAX_PATTERN + POSITION_WIDTH;

    // compare stage
    logic                   s1_valid_reg;
    logic [MAX_PATTERN-1:0] s1_mask_reg;
    logic                   s1_start_reg;
    logic                   fwd_sel_reg;
    logic [ST_W-1:0]        fwd_data_reg;
    logic                   st_valid_reg;
    logic [MAX_PATTERN-1:0] mask_next;

    // update stage
    logic                   accept;
    logic                   advance;
    logic [ST_W-1:0]        ram_rd_data;
    logic [ST_W-1:0]        st_cur;
    logic [ST_W-1:0]        st_new;
    logic [MAX_PATTERN-1:0] vec_cur;
    logic [MAX_PATTERN-1:0] vec_new;
    logic [MAX_PATTERN-1:0] vec_shr;
    logic [POSITION_WIDTH-1:0] pos_cur;
    logic [POSITION_WIDTH-1:0] pos_new;
    logic                   found_cur;
    logic [LEN_W-1:0]       len_eff;
    logic [LEN_W-1:0]       len_m1;
    logic                   hit;
    logic                   sat;
    logic [POSITION_WIDTH:0] pos_p1;
    logic [POSITION_WIDTH:0] hs_full;

    // result register
    logic                   m_valid_reg;
    logic                   m_hit_reg;
    logic [HIT_START_W-1:0] m_hit_start_reg;
    logic                   m_first_hit_reg;
    logic                   m_sat_reg;

    assign advance = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !s1_valid_reg || advance;
    assign accept  = s_valid && s_ready;

    always_comb begin
        for (int k = 0; k < MAX_PATTERN; k++) begin
            mask_next[k] = (cfg.pattern[k*BYTE_W +: BYTE_W] == s_text_byte);
        end
    end

    ssu_ram #(
        .WIDTH (ST_W),
        .DEPTH (1)
    ) u_state_ram (
        .clk     (aclk),
        .wr_en   (advance),
        .wr_addr ('0),
        .wr_data (st_new),
        .rd_en   (accept),
        .rd_addr ('0),
        .rd_data (ram_rd_data)
    );

    // current state: text start, bypass of a same-edge write, stored word, reset value
    always_comb begin
        if (s1_start_reg) begin
            st_cur = '0;
        end else if (fwd_sel_reg) begin
            st_cur = fwd_data_reg;
        end else if (st_valid_reg) begin
            st_cur = ram_rd_data;
        end else begin
            st_cur = '0;
        end
    end

    assign vec_cur   = st_cur[VEC_LO +: MAX_PATTERN];
    assign pos_cur   = st_cur[POS_LO +: POSITION_WIDTH];
    assign found_cur = st_cur[FND_B];

    always_comb begin
        if (cfg.length == '0) begin
            len_eff = LEN_W'(1);
        end else if (cfg.length > LEN_W'(MAX_PATTERN)) begin
            len_eff = LEN_W'(MAX_PATTERN);
        end else begin
            len_eff = cfg.length;
        end
    end

    assign len_m1  = len_eff - LEN_W'(1);
    assign vec_new = ((vec_cur << 1) | MAX_PATTERN'(1)) & s1_mask_reg;
    assign vec_shr = vec_new >> len_m1;
    assign hit     = vec_shr[0];
    assign sat     = &pos_cur;
    assign pos_new = sat ? pos_cur : pos_cur + POSITION_WIDTH'(1);
    assign pos_p1  = {1'b0, pos_cur} + (POSITION_WIDTH+1)'(1);

    always_comb begin
        if (!hit) begin
            hs_full = '0;
        end else if (pos_p1 >= (POSITION_WIDTH+1)'(len_eff)) begin
            hs_full = pos_p1 - (POSITION_WIDTH+1)'(len_eff);
        end else begin
            hs_full = '0;
        end
    end

    assign st_new = {found_cur | hit, pos_new, vec_new};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            st_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (accept) begin
                s1_valid_reg <= 1'b1;
            end else if (advance) begin
                s1_valid_reg <= 1'b0;
            end
            if (advance) begin
                st_valid_reg <= 1'b1;
            end
            if (advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (accept) begin
            s1_mask_reg  <= mask_next;
            s1_start_reg <= s_text_start;
            fwd_sel_reg  <= advance;
            fwd_data_reg <= st_new;
        end
        if (advance) begin
            m_hit_reg       <= hit;
            m_hit_start_reg <= HIT_START_W'(hs_full[POSITION_WIDTH-1:0]);
            m_first_hit_reg <= hit && !found_cur;
            m_sat_reg       <= sat;
        end
    end

    assign m_valid              = m_valid_reg;
    assign m_hit                = m_hit_reg;
    assign m_hit_start          = m_hit_start_reg;
    assign m_first_hit          = m_first_hit_reg;
    assign m_position_saturated = m_sat_reg;

    `SSU_ASSERT_IMPLIES(a_first_needs_hit, aclk, aresetn, m_valid && m_first_hit, m_hit, "first hit without hit")
    `SSU_ASSERT_IMPLIES(a_no_hit_zero_start, aclk, aresetn, m_valid && !m_hit, m_hit_start == '0, "hit_start nonzero without hit")
    `SSU_ASSERT_NEXT(a_stage_holds, aclk, aresetn, s1_valid_reg && !advance, s1_valid_reg, "compare stage dropped a transaction")
    `SSU_ASSERT_NEXT(a_write_marks_state, aclk, aresetn, advance, st_valid_reg && m_valid_reg, "state write without result")

endmodule
